// ===== hdl/esm_pkg.sv =====
package esm_pkg;

    localparam int MAX_NEEDLE      = 32;
    localparam int POS_BITS        = 16;
    localparam int NEEDLE_LEN_BITS = 6;
    localparam int NEEDLE_WORDS    = 4;
    localparam int CFG_DATA_BITS   = 64;
    localparam int CFG_ADDR_BITS   = 6;
    localparam int CFG_INDEX_BITS  = 3;

    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_NEEDLE_LENGTH = 3'd0,
        REG_NEEDLE_LOW    = 3'd1,
        REG_NEEDLE_SECOND = 3'd2,
        REG_NEEDLE_THIRD  = 3'd3,
        REG_NEEDLE_HIGH   = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [7:0]          text_byte;
        logic                first_byte;
        logic                last_byte;
        logic [POS_BITS-1:0] start_position;
    } text_item_t;

    typedef struct packed {
        logic                found;
        logic [POS_BITS-1:0] match_position;
        logic                length_overflow;
    } result_item_t;

endpackage

// ===== hdl/exact_substring_matcher.sv =====
// Latency: a result is valid in the cycle after the item marked last_byte is accepted.
// Throughput: one text byte per cycle; the window compare of all needle bytes against
// the byte history is a single pass of logic between the state and result registers.
// The input stalls only while a finished result waits on result_ready.
// Reset (rst_n, asynchronous, active low) clears the text state, sets needle_length
// to 1, clears the needle bytes and drops result_valid.
module exact_substring_matcher
    import esm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     text_valid,
    output logic                     text_ready,
    input  text_item_t               text_item,

    output logic                     result_valid,
    input  logic                     result_ready,
    output result_item_t             result_item,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    logic [NEEDLE_LEN_BITS-1:0] needle_length_reg;
    logic [CFG_DATA_BITS-1:0]   needle_word_reg [NEEDLE_WORDS];

    logic [7:0]          recent_reg [MAX_NEEDLE];
    logic [POS_BITS-1:0] count_reg;
    logic [POS_BITS-1:0] limit_reg;
    logic                seen_reg;
    logic [POS_BITS-1:0] first_start_reg;
    logic                sat_reg;

    logic                result_valid_reg;
    result_item_t        result_reg;

    logic                       cfg_write;
    reg_index_t                 cfg_index;
    logic [NEEDLE_LEN_BITS-1:0] len_used;
    logic [7:0]                 needle_aligned [MAX_NEEDLE];
    logic [MAX_NEEDLE-1:0]      needle_mask;
    logic [7:0]                 window_next [MAX_NEEDLE];
    logic                       hit;

    logic                accept;
    logic [POS_BITS-1:0] pos_cur;
    logic                sat_cur;
    logic                seen_cur;
    logic [POS_BITS-1:0] first_start_cur;
    logic [POS_BITS-1:0] limit_cur;
    logic                sat_next;
    logic [POS_BITS:0]   pos_inc;
    logic                long_enough;
    logic [POS_BITS-1:0] start_cand;
    logic                record;
    logic                seen_next;
    logic [POS_BITS-1:0] first_start_next;
    logic [POS_BITS-1:0] count_next;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = reg_index_t'(paddr[CFG_ADDR_BITS-1 -: CFG_INDEX_BITS]);

    always_comb
    begin
        case (cfg_index)
            REG_NEEDLE_LENGTH: prdata = CFG_DATA_BITS'(needle_length_reg);
            REG_NEEDLE_LOW:    prdata = needle_word_reg[0];
            REG_NEEDLE_SECOND: prdata = needle_word_reg[1];
            REG_NEEDLE_THIRD:  prdata = needle_word_reg[2];
            REG_NEEDLE_HIGH:   prdata = needle_word_reg[3];
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_length_reg <= NEEDLE_LEN_BITS'(1);
            for (int w = 0; w < NEEDLE_WORDS; w++)
            begin
                needle_word_reg[w] <= '0;
            end
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_NEEDLE_LENGTH: needle_length_reg  <= pwdata[NEEDLE_LEN_BITS-1:0];
                REG_NEEDLE_LOW:    needle_word_reg[0] <= pwdata;
                REG_NEEDLE_SECOND: needle_word_reg[1] <= pwdata;
                REG_NEEDLE_THIRD:  needle_word_reg[2] <= pwdata;
                REG_NEEDLE_HIGH:   needle_word_reg[3] <= pwdata;
                default:           ;
            endcase
        end
    end

    // Out-of-range lengths are clamped into 1 to MAX_NEEDLE.
    always_comb
    begin
        if (needle_length_reg == '0)
        begin
            len_used = NEEDLE_LEN_BITS'(1);
        end
        else if (needle_length_reg > NEEDLE_LEN_BITS'(MAX_NEEDLE))
        begin
            len_used = NEEDLE_LEN_BITS'(MAX_NEEDLE);
        end
        else
        begin
            len_used = needle_length_reg;
        end
    end

    // The needle is reversed so that window slot k (k bytes back from the newest)
    // lines up with needle byte len-1-k. This depends on configuration only.
    always_comb
    begin
        logic [NEEDLE_LEN_BITS-1:0] idx;
        idx = '0;
        for (int k = 0; k < MAX_NEEDLE; k++)
        begin
            idx               = len_used - NEEDLE_LEN_BITS'(1) - NEEDLE_LEN_BITS'(k);
            needle_mask[k]    = NEEDLE_LEN_BITS'(k) < len_used;
            needle_aligned[k] = needle_word_reg[idx[4:3]][{idx[2:0], 3'b000} +: 8];
        end
    end

    // The window is not cleared between texts: a match needs len_used bytes of the
    // current text, so a compare that reaches older contents is never recorded.
    always_comb
    begin
        window_next[0] = text_item.text_byte;
        for (int k = 1; k < MAX_NEEDLE; k++)
        begin
            window_next[k] = recent_reg[k-1];
        end
        hit = 1'b1;
        for (int k = 0; k < MAX_NEEDLE; k++)
        begin
            if (needle_mask[k] && (window_next[k] != needle_aligned[k]))
            begin
                hit = 1'b0;
            end
        end
    end

    assign text_ready = !result_valid_reg || result_ready;
    assign accept     = text_valid && text_ready;

    always_comb
    begin
        pos_cur         = text_item.first_byte ? '0 : count_reg;
        sat_cur         = text_item.first_byte ? 1'b0 : sat_reg;
        seen_cur        = text_item.first_byte ? 1'b0 : seen_reg;
        first_start_cur = text_item.first_byte ? '0 : first_start_reg;
        limit_cur       = text_item.first_byte ? text_item.start_position : limit_reg;

        sat_next    = sat_cur || (pos_cur == POS_MAX);
        pos_inc     = {1'b0, pos_cur} + (POS_BITS+1)'(1);
        long_enough = pos_inc >= (POS_BITS+1)'(len_used);
        start_cand  = POS_BITS'(pos_inc - (POS_BITS+1)'(len_used));
        record      = !sat_next && !seen_cur && long_enough && hit
                      && (start_cand >= limit_cur);

        seen_next        = seen_cur || record;
        first_start_next = record ? start_cand : first_start_cur;
        count_next       = sat_next ? pos_cur : pos_inc[POS_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_NEEDLE; k++)
            begin
                recent_reg[k] <= '0;
            end
            count_reg       <= '0;
            limit_reg       <= '0;
            seen_reg        <= 1'b0;
            first_start_reg <= '0;
            sat_reg         <= 1'b0;
        end
        else if (accept)
        begin
            for (int k = 0; k < MAX_NEEDLE; k++)
            begin
                recent_reg[k] <= window_next[k];
            end
            limit_reg <= limit_cur;
            if (text_item.last_byte)
            begin
                count_reg       <= '0;
                seen_reg        <= 1'b0;
                first_start_reg <= '0;
                sat_reg         <= 1'b0;
            end
            else
            begin
                count_reg       <= count_next;
                seen_reg        <= seen_next;
                first_start_reg <= first_start_next;
                sat_reg         <= sat_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (accept && text_item.last_byte)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && text_item.last_byte)
        begin
            result_reg.found           <= seen_next;
            result_reg.match_position  <= seen_next ? first_start_next : '0;
            result_reg.length_overflow <= sat_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_reg;

`ifndef SYNTHESIS
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && text_item.last_byte |=> result_valid)
        else $error("accepted last byte did not produce a result");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !text_item.last_byte && !result_valid_reg |=> !result_valid)
        else $error("result appeared without a last byte");

    a_not_found_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_item.found |-> result_item.match_position == '0)
        else $error("match position nonzero without a match");

    a_sat_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
        sat_reg |-> count_reg == POS_MAX)
        else $error("saturated flag set while counter below maximum");

    a_match_after_limit: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg |-> first_start_reg >= limit_reg)
        else $error("recorded match starts before the start position");
`endif

endmodule
